/* sv/tedb_pkg.sv */
// tedb_pkg: shared types, codes and key classification for the text edit buffer
// used by tedb_ctrl, tedb_store and text_edit_buffer_core; no dependencies
package tedb_pkg;

  localparam int CAPACITY_DEF = 8192;
  localparam int CNT_W        = 14;
  localparam int IDX_W        = 13;
  localparam int OP_W         = 2;
  localparam int BYTE_W       = 8;

  localparam logic [CNT_W-1:0]  COUNT_MAX = 14'h3FFF;
  localparam logic [BYTE_W-1:0] CPR_RESET = 8'd76;

  localparam logic [OP_W-1:0] OP_KEY  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;
  localparam logic [BYTE_W-1:0] KEY_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] KEY_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] KEY_BS   = 8'h08;
  localparam logic [BYTE_W-1:0] KEY_DEL  = 8'h7F;

  typedef enum logic [1:0] {
    KC_NONE    = 2'd0,
    KC_PRINT   = 2'd1,
    KC_NEWLINE = 2'd2,
    KC_DELETE  = 2'd3
  } key_kind_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INS  = 5'b00010,
    ST_PUT  = 5'b00100,
    ST_DEL  = 5'b01000,
    ST_RD   = 5'b10000
  } state_t;

  function automatic key_kind_t key_class(input logic [BYTE_W-1:0] k);
    key_kind_t kc;
    kc = KC_NONE;
    if (k inside {[PRINT_LO:PRINT_HI]}) begin
      kc = KC_PRINT;
    end else if (k inside {KEY_LF, KEY_CR}) begin
      kc = KC_NEWLINE;
    end else if (k inside {KEY_BS, KEY_DEL}) begin
      kc = KC_DELETE;
    end
    return kc;
  endfunction

endpackage

/* sv/text_edit_buffer_core.sv */
// text_edit_buffer_core: insert at cursor moves the bytes after it up one place, last first,
// then writes the key; delete moves them down one place; read, load, refused or ignored ops
// and insert or delete at the end move no bytes; the tail moves one byte per cycle through
// the store ports; a new start is taken in the cycle the strobe shows; results cannot be stalled
// synchronous active-low reset clears length, cursor, row, column; columns_per_row to 76
// store contents are undefined after reset and get no clearing pass
module text_edit_buffer_core #(
  parameter int CAPACITY = tedb_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tedb_pkg::OP_W-1:0]   in_op,
  input  logic [tedb_pkg::BYTE_W-1:0] in_key_code,
  input  logic [tedb_pkg::IDX_W-1:0]  in_read_index,
  input  logic                        cfg_wr_en,
  input  logic [tedb_pkg::BYTE_W-1:0] cfg_wr_data,
  output logic                        out_strobe,
  output logic                        out_changed,
  output logic [tedb_pkg::BYTE_W-1:0] out_read_byte,
  output logic [tedb_pkg::CNT_W-1:0]  out_text_length,
  output logic [tedb_pkg::CNT_W-1:0]  out_cursor_index,
  output logic [tedb_pkg::CNT_W-1:0]  out_cursor_line,
  output logic [tedb_pkg::CNT_W-1:0]  out_cursor_column,
  output logic                        out_store_full
);
  import tedb_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [BYTE_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [BYTE_W-1:0] mem_rd_data;

  tedb_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_key_code       (in_key_code),
    .in_read_index     (in_read_index),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_strobe        (out_strobe),
    .out_changed       (out_changed),
    .out_read_byte     (out_read_byte),
    .out_text_length   (out_text_length),
    .out_cursor_index  (out_cursor_index),
    .out_cursor_line   (out_cursor_line),
    .out_cursor_column (out_cursor_column),
    .out_store_full    (out_store_full),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data),
    .mem_rd_en         (mem_rd_en),
    .mem_rd_addr       (mem_rd_addr),
    .mem_rd_data       (mem_rd_data)
  );

  tedb_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

/* sv/tedb_store.sv */
// tedb_store: byte text memory, one write port and one read port
// read data registered; uses tedb_pkg
module tedb_store #(
  parameter int DEPTH = tedb_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [tedb_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [tedb_pkg::BYTE_W-1:0] rd_data
);
  import tedb_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/tedb_ctrl.sv */
// tedb_ctrl: sequencer for key, read and load ops; moves the tail one byte per cycle
// holds length, cursor, row, column and columns_per_row; uses tedb_pkg, drives tedb_store
module tedb_ctrl #(
  parameter int CAPACITY = tedb_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tedb_pkg::OP_W-1:0]   in_op,
  input  logic [tedb_pkg::BYTE_W-1:0] in_key_code,
  input  logic [tedb_pkg::IDX_W-1:0]  in_read_index,
  input  logic                        cfg_wr_en,
  input  logic [tedb_pkg::BYTE_W-1:0] cfg_wr_data,
  output logic                        out_strobe,
  output logic                        out_changed,
  output logic [tedb_pkg::BYTE_W-1:0] out_read_byte,
  output logic [tedb_pkg::CNT_W-1:0]  out_text_length,
  output logic [tedb_pkg::CNT_W-1:0]  out_cursor_index,
  output logic [tedb_pkg::CNT_W-1:0]  out_cursor_line,
  output logic [tedb_pkg::CNT_W-1:0]  out_cursor_column,
  output logic                        out_store_full,
  output logic                        mem_wr_en,
  output logic [AW-1:0]               mem_wr_addr,
  output logic [tedb_pkg::BYTE_W-1:0] mem_wr_data,
  output logic                        mem_rd_en,
  output logic [AW-1:0]               mem_rd_addr,
  input  logic [tedb_pkg::BYTE_W-1:0] mem_rd_data
);
  import tedb_pkg::*;

  localparam int CW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam logic [AW-1:0] FULL_LEN = AW'(CAPACITY - 1);
  localparam logic [AW-1:0] ONE      = AW'(1);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     length_r, length_nxt;
  logic [AW-1:0]     cursor_r, cursor_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [BYTE_W-1:0] cpr_r, cpr_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  key_kind_t         kind_r, kind_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              strobe_r, strobe_nxt;
  logic              changed_r, changed_nxt;
  logic [BYTE_W-1:0] rdb_r, rdb_nxt;

  key_kind_t         kc_in;
  key_kind_t         kind_sel;
  logic [BYTE_W-1:0] byte_in;
  logic              full;
  logic              apply;

  assign kc_in   = key_class(in_key_code);
  assign byte_in = (kc_in == KC_PRINT) ? in_key_code : KEY_LF;
  assign full    = (length_r == FULL_LEN);
  assign busy    = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    length_nxt  = length_r;
    cursor_nxt  = cursor_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    cpr_nxt     = cfg_wr_en ? cfg_wr_data : cpr_r;
    ptr_nxt     = ptr_r;
    kind_nxt    = kind_r;
    byte_nxt    = byte_r;
    strobe_nxt  = 1'b0;
    changed_nxt = 1'b0;
    rdb_nxt     = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    apply       = 1'b0;
    kind_sel    = kind_r;

    case (state_r)
      ST_IDLE: begin
        kind_sel = kc_in;
        if (start) begin
          kind_nxt = kc_in;
          byte_nxt = byte_in;
          case (in_op)
            OP_KEY: begin
              case (kc_in)
                KC_PRINT, KC_NEWLINE: begin
                  if (full) begin
                    strobe_nxt = 1'b1;
                  end else if (cursor_r == length_r) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = cursor_r;
                    mem_wr_data = byte_in;
                    apply       = 1'b1;
                  end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = length_r - ONE;
                    ptr_nxt     = length_r - ONE;
                    state_nxt   = ST_INS;
                  end
                end
                KC_DELETE: begin
                  if (cursor_r == '0) begin
                    strobe_nxt = 1'b1;
                  end else if (cursor_r == length_r) begin
                    apply = 1'b1;
                  end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cursor_r;
                    ptr_nxt     = cursor_r;
                    state_nxt   = ST_DEL;
                  end
                end
                default: begin
                  strobe_nxt = 1'b1;
                end
              endcase
            end
            OP_READ: begin
              if (CW'(in_read_index) < CW'(length_r)) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(in_read_index);
                state_nxt   = ST_RD;
              end else begin
                strobe_nxt = 1'b1;
              end
            end
            OP_LOAD: begin
              strobe_nxt = 1'b1;
              if (!full) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = length_r;
                mem_wr_data = in_key_code;
                length_nxt  = length_r + ONE;
                changed_nxt = 1'b1;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_INS: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr_r + ONE;
        mem_wr_data = mem_rd_data;
        if (ptr_r == cursor_r) begin
          state_nxt = ST_PUT;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_r - ONE;
          ptr_nxt     = ptr_r - ONE;
        end
      end
      ST_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cursor_r;
        mem_wr_data = byte_r;
        apply       = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_DEL: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr_r - ONE;
        mem_wr_data = mem_rd_data;
        if (ptr_r == length_r - ONE) begin
          apply     = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_r + ONE;
          ptr_nxt     = ptr_r + ONE;
        end
      end
      ST_RD: begin
        rdb_nxt    = mem_rd_data;
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (apply) begin
      strobe_nxt  = 1'b1;
      changed_nxt = 1'b1;
      case (kind_sel)
        KC_PRINT: begin
          cursor_nxt = cursor_r + ONE;
          length_nxt = length_r + ONE;
          col_nxt    = (col_r < COUNT_MAX) ? col_r + CNT_W'(1) : col_r;
        end
        KC_NEWLINE: begin
          cursor_nxt = cursor_r + ONE;
          length_nxt = length_r + ONE;
          row_nxt    = (row_r < COUNT_MAX) ? row_r + CNT_W'(1) : row_r;
          col_nxt    = '0;
        end
        KC_DELETE: begin
          cursor_nxt = cursor_r - ONE;
          length_nxt = length_r - ONE;
          if (col_r != '0) begin
            col_nxt = col_r - CNT_W'(1);
          end else begin
            col_nxt = (cpr_r != '0) ? CNT_W'(cpr_r) - CNT_W'(1) : '0;
            row_nxt = (row_r != '0) ? row_r - CNT_W'(1) : row_r;
          end
        end
        default: begin
          changed_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      length_r <= '0;
      cursor_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
      cpr_r    <= CPR_RESET;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      length_r <= length_nxt;
      cursor_r <= cursor_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      cpr_r    <= cpr_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    kind_r    <= kind_nxt;
    byte_r    <= byte_nxt;
    changed_r <= changed_nxt;
    rdb_r     <= rdb_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_changed       = changed_r;
  assign out_read_byte     = rdb_r;
  assign out_text_length   = CNT_W'(length_r);
  assign out_cursor_index  = CNT_W'(cursor_r);
  assign out_cursor_line   = row_r;
  assign out_cursor_column = col_r;
  assign out_store_full    = full;

endmodule

/* sv/tedb_check.sv */
// tedb_check: port-level assertions for text_edit_buffer_core, attached by bind
// uses tedb_pkg widths; sees the top level ports only
module tedb_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic                        out_changed,
  input logic [tedb_pkg::BYTE_W-1:0] out_read_byte,
  input logic [tedb_pkg::CNT_W-1:0]  out_text_length,
  input logic [tedb_pkg::CNT_W-1:0]  out_cursor_index
);

  // a result word only shows once the sequencer is back to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result word while busy");

  // every accepted word either starts work or answers in the next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted word neither busy nor answered");

  // a nonzero read byte only comes from a read, which never changes anything
  a_read_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_read_byte != '0) |-> !out_changed)
    else $error("read word reports a change");

  // every change inserts or removes one byte
  a_change_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_changed) |-> (out_text_length != $past(out_text_length)))
    else $error("change without length step");

  // with nothing accepted and idle, the counts hold
  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> ($stable(out_text_length) && $stable(out_cursor_index)))
    else $error("counts moved while idle");

endmodule

bind text_edit_buffer_core tedb_check u_tedb_check (.*);
